// ===== rtl/lifo_stack_with_search_core_macros.svh =====
// ----------------------------------------------------------------------------
// lifo stack with search: assertion macros
// concurrent checks clocked on clk, with or without the reset gate
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_SEARCH_CORE_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_CORE_MACROS_SVH

// check gated off while arst_n is low
`define LFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that also holds during reset
`define LFS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/lfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfs_pkg
// operation codes, field widths and shared types of the lifo stack
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfs_pkg;

	localparam int WORD_W  = 32;
	localparam int FUNC_W  = 2;
	localparam int CNT_OUT_W = 7;
	localparam int OUT_DATA_W = 48;

	localparam logic [FUNC_W-1:0] FN_PUSH = 2'd0;
	localparam logic [FUNC_W-1:0] FN_POP  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_FIND = 2'd2;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/lifo_stack_with_search_core.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_search_core
// bounded lifo of signed words with push, pop and a contains search
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                   | tuser
//  s_*     | in  | value[31:0]                             | func[1:0]
//  m_*     | out | data_out, found, underflow, overflow,   | data_valid
//          |     | count[6:0], empty_res                   |
//
//  push, no-op, refused push, pop leaving the stack empty, search of empty: result registered as taken
//  pop leaving words behind: the new top is then read back from the store in ST_POP_RD
//  search: ST_SRCH reads one stored word per cycle through the single
//  read port and one comparator, stopping at the first match
//  no clearing pass after reset, the store is only read below the fill count
//  the next item is taken only in ST_IDLE while the output register is empty or draining
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lifo_stack_with_search_core_macros.svh"

module lifo_stack_with_search_core #(
	parameter int DEPTH = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,  // value[31:0]
	input  wire  [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,  // data_out[31:0], found, underflow, overflow,
	                              // count[41:35], empty_res, zero pad
	output logic [0:0]  m_tuser   // data_valid
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = lfs_pkg::WORD_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_SRCH
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic signed [WW-1:0]   top_q;
	logic signed [WW-1:0]   val_q;
	logic [AW-1:0]          idx_q;
	logic                   more_q;
	logic                   pend_q;
	logic                   m_tvalid_q;
	logic [47:0]            m_tdata_q;
	logic                   m_tuser_q;

	logic                   out_free;
	logic                   acc;
	logic [lfs_pkg::FUNC_W-1:0] func;
	logic signed [WW-1:0]   value;
	logic                   full;
	logic                   empty;
	logic [CW-1:0]          cnt_m2;
	logic                   eq;

	lfs_pkg::mem_ctl_t      mem_ctl;
	logic [AW-1:0]          rd_addr;
	logic signed [WW-1:0]   rd_data;

	logic                   emit_en;
	logic signed [WW-1:0]   e_word;
	logic                   e_valid;
	logic                   e_found;
	logic                   e_under;
	logic                   e_over;
	logic [CW-1:0]          cnt_n;
	logic [CW+6:0]          cnt_wide;
	logic [6:0]             cnt7;
	logic signed [WW-1:0]   dout;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign acc      = s_tvalid && s_tready;
	assign func     = s_tuser;
	assign value    = s_tdata;
	assign full     = count_q == CW'(DEPTH);
	assign empty    = count_q == '0;
	assign cnt_m2   = count_q - CW'(2);
	assign eq       = rd_data == val_q;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		mem_ctl.wr_en = acc && (func == lfs_pkg::FN_PUSH) && !full;
		mem_ctl.rd_en = 1'b0;
		rd_addr       = idx_q;
		case (state_q)
			ST_IDLE: begin
				rd_addr = cnt_m2[AW-1:0];
				mem_ctl.rd_en = acc && (func == lfs_pkg::FN_POP) && (count_q > CW'(1));
			end
			ST_SRCH: begin
				mem_ctl.rd_en = more_q;
			end
			default: ;
		endcase
	end

	lfs_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.ctl    (mem_ctl),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(value),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		emit_en = 1'b0;
		e_word  = top_q;
		e_valid = !empty;
		e_found = 1'b0;
		e_under = 1'b0;
		e_over  = 1'b0;
		cnt_n   = count_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					emit_en = 1'b1;
					case (func)
						lfs_pkg::FN_PUSH: begin
							if (full) begin
								e_over = 1'b1;
							end else begin
								cnt_n   = count_q + CW'(1);
								e_word  = value;
								e_valid = 1'b1;
							end
						end
						lfs_pkg::FN_POP: begin
							if (empty) begin
								e_under = 1'b1;
							end else begin
								cnt_n = count_q - CW'(1);
							end
						end
						lfs_pkg::FN_FIND: begin
							emit_en = empty;
						end
						default: ;
					endcase
				end
			end
			ST_SRCH: begin
				if (pend_q && (eq || !more_q)) begin
					emit_en = 1'b1;
					e_found = eq;
				end
			end
			default: ;
		endcase
	end

	assign cnt_wide = {7'd0, cnt_n};
	assign cnt7     = cnt_wide[6:0];
	assign dout     = e_valid ? e_word : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			top_q      <= '0;
			val_q      <= '0;
			idx_q      <= '0;
			more_q     <= 1'b0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
		end else begin
			count_q <= cnt_n;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (emit_en) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {5'd0, cnt_n == '0, cnt7, e_over, e_under, e_found, dout};
				m_tuser_q  <= e_valid;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (func == lfs_pkg::FN_PUSH && !full) begin
							top_q <= value;
						end
						if (func == lfs_pkg::FN_POP && count_q > CW'(1)) begin
							state_q <= ST_POP_RD;
						end
						if (func == lfs_pkg::FN_FIND && !empty) begin
							val_q   <= value;
							idx_q   <= cnt_m2[AW-1:0] + AW'(1);
							more_q  <= 1'b1;
							pend_q  <= 1'b0;
							state_q <= ST_SRCH;
						end
					end
				end
				ST_POP_RD: begin
					top_q   <= rd_data;
					state_q <= ST_IDLE;
				end
				ST_SRCH: begin
					if (more_q) begin
						idx_q  <= idx_q - AW'(1);
						more_q <= idx_q != '0;
					end
					pend_q <= more_q;
					if (pend_q && (eq || !more_q)) begin
						more_q  <= 1'b0;
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`LFS_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "fill count above depth")
	`LFS_ASSERT(a_busy_not_ready, (state_q != ST_IDLE) |-> !s_tready, "ready while busy")
	`LFS_ASSERT(a_srch_out_empty, (state_q == ST_SRCH) |-> !m_tvalid_q, "result pending in search")
	`LFS_ASSERT(a_valid_not_empty, (m_tvalid && !m_tdata[42]) |-> m_tuser[0],
		"no valid word on non-empty stack")
	`LFS_ASSERT(a_pop_rd_once, (state_q == ST_POP_RD) |=> (state_q == ST_IDLE),
		"top reload longer than one cycle")

endmodule

`default_nettype wire

// ===== rtl/lfs_mem.sv =====
// ----------------------------------------------------------------------------
// lfs_mem
// word store of the stack: one write port, one read port with registered data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfs_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  wire                            clk,
	input  wire lfs_pkg::mem_ctl_t         ctl,
	input  wire [AW-1:0]                   wr_addr,
	input  wire signed [lfs_pkg::WORD_W-1:0] wr_data,
	input  wire [AW-1:0]                   rd_addr,
	output logic signed [lfs_pkg::WORD_W-1:0] rd_data
);

	logic signed [lfs_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== test/lifo_stack_with_search_core_tb.sv =====
// ----------------------------------------------------------------------------
// lifo_stack_with_search_core_tb
// Self-checking bench for the bounded lifo with push, pop and contains search.
// A directed table covers reset state, word extremes, every function code,
// pop on an empty stack and search misses. Random phases then fill past full,
// drain past empty and mix searches for stored and absent words. Each result
// is checked in order against a typed table row or a predictor that mirrors the
// stack contents. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lifo_stack_with_search_core_tb;

	localparam int DEPTH = 64;
	localparam int RANDOM_ITEMS = 650;
	localparam int MAX_REPORTS = 10;
	localparam logic [lfs_pkg::FUNC_W-1:0] FN_NOP = 2'd3;

	typedef struct packed {
		logic [lfs_pkg::WORD_W-1:0]    data_out;
		logic                          data_valid;
		logic                          found;
		logic                          underflow;
		logic                          overflow;
		logic [lfs_pkg::CNT_OUT_W-1:0] count;
		logic                          empty_res;
	} stack_result_t;

	typedef struct packed {
		logic [lfs_pkg::FUNC_W-1:0] func;
		logic [lfs_pkg::WORD_W-1:0] value;
		logic                       typed;
		stack_result_t              res;
	} stack_row_t;

	localparam int DIRECTED_ROWS = 23;
	localparam stack_row_t DIRECTED_TBL [DIRECTED_ROWS] = '{
		'{lfs_pkg::FN_POP,  32'h0000_0000, 1'b1,
			'{32'h0, 1'b0, 1'b0, 1'b1, 1'b0, 7'd0, 1'b1}},
		'{lfs_pkg::FN_FIND, 32'h0000_0000, 1'b1,
			'{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b1}},
		'{FN_NOP,  32'hffff_ffff, 1'b1,
			'{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b1}},
		'{lfs_pkg::FN_PUSH, 32'h7fff_ffff, 1'b1,
			'{32'h7fff_ffff, 1'b1, 1'b0, 1'b0, 1'b0, 7'd1, 1'b0}},
		'{lfs_pkg::FN_PUSH, 32'h8000_0000, 1'b1,
			'{32'h8000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 7'd2, 1'b0}},
		'{lfs_pkg::FN_FIND, 32'h7fff_ffff, 1'b0, '0},
		'{lfs_pkg::FN_FIND, 32'h8000_0000, 1'b0, '0},
		'{lfs_pkg::FN_FIND, 32'h0000_0000, 1'b0, '0},
		'{lfs_pkg::FN_PUSH, 32'h0000_0000, 1'b0, '0},
		'{lfs_pkg::FN_PUSH, 32'hffff_ffff, 1'b0, '0},
		'{lfs_pkg::FN_PUSH, 32'haaaa_aaaa, 1'b0, '0},
		'{lfs_pkg::FN_PUSH, 32'h5555_5555, 1'b0, '0},
		'{lfs_pkg::FN_FIND, 32'h0000_0000, 1'b0, '0},
		'{lfs_pkg::FN_FIND, 32'h0000_0001, 1'b0, '0},
		'{FN_NOP,  32'h0000_0000, 1'b0, '0},
		'{lfs_pkg::FN_POP,  32'h0000_0000, 1'b0, '0},
		'{lfs_pkg::FN_POP,  32'hffff_ffff, 1'b0, '0},
		'{lfs_pkg::FN_POP,  32'h0000_0000, 1'b0, '0},
		'{lfs_pkg::FN_POP,  32'h0000_0000, 1'b0, '0},
		'{lfs_pkg::FN_POP,  32'h0000_0000, 1'b0, '0},
		'{lfs_pkg::FN_POP,  32'h0000_0000, 1'b0, '0},
		'{lfs_pkg::FN_POP,  32'h1234_5678, 1'b1,
			'{32'h0, 1'b0, 1'b0, 1'b1, 1'b0, 7'd0, 1'b1}},
		'{lfs_pkg::FN_FIND, 32'h7fff_ffff, 1'b1,
			'{32'h0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0, 1'b1}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;  // value[31:0]
	logic [1:0]  s_tuser = '0;  // func[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;       // data_out[31:0], found, underflow, overflow,
	                            // count[41:35], empty_res, zero pad
	logic [0:0]  m_tuser;       // data_valid

	logic [lfs_pkg::WORD_W-1:0] stack_words [DEPTH];
	int                stack_fill = 0;
	stack_result_t     pending_results [$];
	int                mismatch_cnt = 0;
	int                src_run_left = 0;
	logic              src_calm = 1'b0;

	lifo_stack_with_search_core #(
		.DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	function automatic stack_result_t predict_stack_op(
		input logic [lfs_pkg::FUNC_W-1:0] fn,
		input logic [lfs_pkg::WORD_W-1:0] val);
		stack_result_t r;
		int i;
		r = '0;
		case (fn)
			lfs_pkg::FN_PUSH: begin
				if (stack_fill >= DEPTH) begin
					r.overflow = 1'b1;
				end else begin
					stack_words[stack_fill] = val;
					stack_fill++;
				end
			end
			lfs_pkg::FN_POP: begin
				if (stack_fill == 0) begin
					r.underflow = 1'b1;
				end else begin
					r.data_out = stack_words[stack_fill-1];
					r.data_valid = 1'b1;
					stack_fill--;
				end
			end
			lfs_pkg::FN_FIND: begin
				for (i = stack_fill - 1; i >= 0; i--)
					if (stack_words[i] == val)
						r.found = 1'b1;
			end
			default: ;
		endcase
		if (fn != lfs_pkg::FN_POP && stack_fill != 0) begin
			r.data_out = stack_words[stack_fill-1];
			r.data_valid = 1'b1;
		end
		r.count = stack_fill[lfs_pkg::CNT_OUT_W-1:0];
		r.empty_res = (stack_fill == 0);
		return r;
	endfunction

	// one slave-side transaction, predicted at the edge where it is taken
	task automatic send_stack_op(input logic [lfs_pkg::FUNC_W-1:0] fn,
		input logic [lfs_pkg::WORD_W-1:0] val,
		input logic typed, input stack_result_t typed_res);
		int gap;
		stack_result_t pred;
		if (src_run_left == 0) begin
			src_calm = ($urandom_range(0, 3) == 0);
			src_run_left = $urandom_range(10, 60);
		end
		src_run_left--;
		gap = src_calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= val;
		s_tuser <= fn;
		do @(posedge clk); while (!s_tready);
		pred = predict_stack_op(fn, val);
		pending_results.push_back(typed ? typed_res : pred);
		@(negedge clk);
	endtask

	function automatic logic [lfs_pkg::WORD_W-1:0] pick_word(input logic for_find);
		int sel;
		sel = $urandom_range(0, 7);
		if (for_find && stack_fill > 0 && sel < 3)
			return stack_words[$urandom_range(0, stack_fill - 1)];
		if (sel < 5)
			return $urandom;
		if (sel == 5)
			return $urandom_range(0, 7);
		case ($urandom_range(0, 3))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			default: return 32'h0000_0000;
		endcase
	endfunction

	initial begin
		int n;
		int phase_left;
		int phase_kind;
		int roll;
		logic [lfs_pkg::FUNC_W-1:0] fn;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (n = 0; n < DIRECTED_ROWS; n++)
			send_stack_op(DIRECTED_TBL[n].func, DIRECTED_TBL[n].value,
				DIRECTED_TBL[n].typed, DIRECTED_TBL[n].res);
		// phases: fill past full, drain past empty, mixed
		phase_left = 0;
		phase_kind = 0;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				phase_kind = $urandom_range(0, 2);
				phase_left = $urandom_range(20, 90);
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			case (phase_kind)
				0: fn = (roll < 75) ? lfs_pkg::FN_PUSH :
					(roll < 90) ? lfs_pkg::FN_FIND :
					(roll < 95) ? lfs_pkg::FN_POP : FN_NOP;
				1: fn = (roll < 75) ? lfs_pkg::FN_POP :
					(roll < 90) ? lfs_pkg::FN_FIND :
					(roll < 95) ? lfs_pkg::FN_PUSH : FN_NOP;
				default: fn = (roll < 30) ? lfs_pkg::FN_PUSH :
					(roll < 60) ? lfs_pkg::FN_POP :
					(roll < 92) ? lfs_pkg::FN_FIND : FN_NOP;
			endcase
			send_stack_op(fn, pick_word(fn == lfs_pkg::FN_FIND), 1'b0, '0);
		end
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatch_cnt == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// master side: random stalls, in-order compare of each transaction
	initial begin
		int stall;
		int run_left;
		logic calm;
		logic bad;
		stack_result_t got;
		stack_result_t exp_res;
		run_left = 0;
		calm = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (run_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				run_left = $urandom_range(10, 60);
			end
			run_left--;
			stall = calm ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got.data_out = m_tdata[31:0];
			got.found = m_tdata[32];
			got.underflow = m_tdata[33];
			got.overflow = m_tdata[34];
			got.count = m_tdata[41:35];
			got.empty_res = m_tdata[42];
			got.data_valid = m_tuser[0];
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("unexpected transaction: data %h valid %b count %0d",
						got.data_out, got.data_valid, got.count);
			end else begin
				exp_res = pending_results.pop_front();
				bad = (got.data_out != exp_res.data_out) ||
					(got.data_valid != exp_res.data_valid) ||
					(got.found != exp_res.found) ||
					(got.underflow != exp_res.underflow) ||
					(got.overflow != exp_res.overflow) ||
					(got.count != exp_res.count) ||
					(got.empty_res != exp_res.empty_res);
				if (bad) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("mismatch: exp data %h v%b f%b u%b o%b cnt %0d e%b, ",
							exp_res.data_out, exp_res.data_valid, exp_res.found,
							exp_res.underflow, exp_res.overflow, exp_res.count,
							exp_res.empty_res,
							"got data %h v%b f%b u%b o%b cnt %0d e%b",
							got.data_out, got.data_valid, got.found,
							got.underflow, got.overflow, got.count, got.empty_res);
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

endmodule
